@@ sv/rtv_pkg.sv @@
// Shared types and constants of the ribbon trail vertex generator.
package rtv_pkg;

    localparam int HISTORY_DEPTH = 32;
    localparam int IDX_W         = $clog2(HISTORY_DEPTH);

    localparam logic [31:0] HALF_WIDTH_RESET = 32'd13107;

    localparam logic CMD_PUSH   = 1'b0;
    localparam logic CMD_RENDER = 1'b1;

    typedef struct packed {
        logic        command;
        logic [31:0] coord_x;
        logic [31:0] coord_y;
        logic [31:0] coord_z;
    } item_t;

    typedef struct packed {
        logic [31:0] vert_x;
        logic [31:0] vert_y;
        logic [31:0] vert_z;
        logic        lower_edge;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } point_t;

    typedef struct packed {
        logic push;
        logic rotate;
    } hist_ctl_t;

endpackage

@@ sv/ribbon_trail_vertex_generator.sv @@
// Top level of the camera-facing ribbon trail vertex generator.
//
// The block keeps the last HISTORY_DEPTH (32) points of a trail, oldest
// first, all zero after reset. A push transfer (command 0) appends a point and
// busy stays low. A render transfer (command 1) carries the
// camera position and produces 2*HISTORY_DEPTH vertices, an upper then a lower
// vertex per point, oldest point first; the final vertex has last set. Each
// vertex appears on result for exactly one cycle with result_valid high: the
// receiver cannot stall, so it must take every strobe. busy is high from the
// render transfer through the cycle that shows the final vertex; start is
// ignored meanwhile. The work for each point but the newest is the prescale shifts,
// the cross product, up to 29 normalizing shifts, the bit-serial square root (32
// steps) and the three bit-serial divisions (32 steps each), all products on the
// single shared multiplier used for cross product, squares and width scaling; a
// zero cross product skips the steps after it, and the newest point skips all.
// Write half_width (unsigned Q16.16) only while busy is low.
module ribbon_trail_vertex_generator
    import rtv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  item_t       item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    output logic        result_valid,
    output result_t     result
);

    logic [31:0] half_width_reg;
    hist_ctl_t   core_ctl, hist_ctl;
    point_t      in_pt, cur_pt, nxt_pt;
    logic        push_go, render_go;

    // Take configuration at any time; the user only writes while idle
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            half_width_reg <= HALF_WIDTH_RESET;
        else if (cfg_valid && cfg_ready)
            half_width_reg <= cfg_data;
    end

    assign in_pt.x = item.coord_x;
    assign in_pt.y = item.coord_y;
    assign in_pt.z = item.coord_z;

    assign push_go   = start && !busy && (item.command == CMD_PUSH);
    assign render_go = start && !busy && (item.command == CMD_RENDER);

    // Push comes from the port, rotate from the render sequencer
    assign hist_ctl.push   = push_go;
    assign hist_ctl.rotate = core_ctl.rotate;

    rtv_hist u_hist
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (hist_ctl),
        .push_pt (in_pt),
        .cur_pt  (cur_pt),
        .nxt_pt  (nxt_pt)
    );

    rtv_core u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .render       (render_go),
        .cam_pt       (in_pt),
        .half_width   (half_width_reg),
        .cur_pt       (cur_pt),
        .nxt_pt       (nxt_pt),
        .hctl         (core_ctl),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

@@ sv/rtv_hist.sv @@
// Point history shift store with push and rotate.
module rtv_hist
    import rtv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  hist_ctl_t ctl,
    input  point_t    push_pt,
    output point_t    cur_pt,
    output point_t    nxt_pt
);

    point_t ent_reg [HISTORY_DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                ent_reg[i] <= '0;
            end
        end
        else if (ctl.push || ctl.rotate)
        begin
            for (int i = 0; i < HISTORY_DEPTH - 1; i++)
            begin
                ent_reg[i] <= ent_reg[i + 1];
            end
            ent_reg[HISTORY_DEPTH - 1] <= ctl.push ? push_pt : ent_reg[0];
        end
    end

    assign cur_pt = ent_reg[0];
    assign nxt_pt = ent_reg[1];

endmodule

@@ sv/rtv_mul.sv @@
// Shared signed multiplier with registered product.
module rtv_mul
(
    input  logic               clk,
    input  logic signed [33:0] op_a,
    input  logic signed [33:0] op_b,
    output logic signed [67:0] prod
);

    logic signed [67:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

@@ sv/rtv_core.sv @@
// Render sequencer and iterative datapath of the ribbon generator.
module rtv_core
    import rtv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        render,
    input  point_t      cam_pt,
    input  logic [31:0] half_width,
    input  point_t      cur_pt,
    input  point_t      nxt_pt,
    output hist_ctl_t   hctl,
    output logic        busy,
    output logic        result_valid,
    output result_t     result
);

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_LOAD   = 13'b0000000000010,
        S_SHRINK = 13'b0000000000100,
        S_CROSS  = 13'b0000000001000,
        S_ZTEST  = 13'b0000000010000,
        S_NORM   = 13'b0000000100000,
        S_SQ     = 13'b0000001000000,
        S_SQRT   = 13'b0000010000000,
        S_DINIT  = 13'b0000100000000,
        S_DIV    = 13'b0001000000000,
        S_OMUL   = 13'b0010000000000,
        S_UPPER  = 13'b0100000000000,
        S_LOWER  = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    logic [IDX_W-1:0] pcnt_reg;
    logic [2:0]  mcnt_reg;
    logic [4:0]  icnt_reg;
    logic [1:0]  kcnt_reg;
    logic        rot_reg;
    point_t      cam_reg;
    logic        a_neg_reg [3];
    logic [32:0] a_mag_reg [3];
    logic        b_neg_reg [3];
    logic [32:0] b_mag_reg [3];
    logic signed [47:0] c_reg [3];
    logic        c_neg_reg [3];
    logic [46:0] m_reg [3];
    logic [61:0] len2_reg;
    logic [63:0] n_reg, r_reg, bit_reg;
    logic [32:0] rem_reg;
    logic [31:0] low_reg, q_reg;
    logic [31:0] o_reg [3];
    logic        rv_reg;
    result_t     res_reg;

    logic signed [33:0] op_a, op_b;
    logic signed [67:0] prod;

    logic [31:0] p_v [3];
    logic [31:0] n_v [3];
    logic [31:0] c_v [3];
    logic        last_pt;
    logic        a_big, b_big;
    logic        m_small, m_large;
    logic [63:0] sq_try;
    logic [32:0] rem_sh;
    logic [60:0] num;
    logic [64:0] o_sum;
    logic [31:0] o_mag;
    logic [2:0]  j;

    rtv_mul u_mul
    (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    function automatic logic signed [33:0] sval(input logic neg, input logic [32:0] mag);
        logic signed [33:0] v;
        v = $signed({1'b0, mag});
        return neg ? -v : v;
    endfunction

    assign p_v[0] = cur_pt.x;
    assign p_v[1] = cur_pt.y;
    assign p_v[2] = cur_pt.z;
    assign n_v[0] = nxt_pt.x;
    assign n_v[1] = nxt_pt.y;
    assign n_v[2] = nxt_pt.z;
    assign c_v[0] = cam_reg.x;
    assign c_v[1] = cam_reg.y;
    assign c_v[2] = cam_reg.z;

    assign last_pt = (pcnt_reg == IDX_W'(HISTORY_DEPTH - 1));
    assign a_big = (a_mag_reg[0][32:22] != '0) || (a_mag_reg[1][32:22] != '0)
                || (a_mag_reg[2][32:22] != '0);
    assign b_big = (b_mag_reg[0][32:22] != '0) || (b_mag_reg[1][32:22] != '0)
                || (b_mag_reg[2][32:22] != '0);
    assign m_small = (m_reg[0][46:29] == '0) && (m_reg[1][46:29] == '0)
                  && (m_reg[2][46:29] == '0);
    assign m_large = (m_reg[0][46:30] != '0) || (m_reg[1][46:30] != '0)
                  || (m_reg[2][46:30] != '0);
    assign sq_try = r_reg + bit_reg;
    assign rem_sh = {rem_reg[31:0], low_reg[31]};
    assign num = 61'({m_reg[kcnt_reg][29:0], 30'd0}) + 61'(q_reg >> 1);
    assign o_sum = 65'(prod[63:0]) + 65'(64'd1 << 29);
    assign o_mag = o_sum[61:30];
    assign j = mcnt_reg - 3'd1;

    // Multiplier operand select
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        priority if (state_reg == S_CROSS)
        begin
            unique case (mcnt_reg)
                3'd0:
                begin
                    op_a = sval(a_neg_reg[1], a_mag_reg[1]);
                    op_b = sval(b_neg_reg[2], b_mag_reg[2]);
                end
                3'd1:
                begin
                    op_a = sval(a_neg_reg[2], a_mag_reg[2]);
                    op_b = sval(b_neg_reg[1], b_mag_reg[1]);
                end
                3'd2:
                begin
                    op_a = sval(a_neg_reg[2], a_mag_reg[2]);
                    op_b = sval(b_neg_reg[0], b_mag_reg[0]);
                end
                3'd3:
                begin
                    op_a = sval(a_neg_reg[0], a_mag_reg[0]);
                    op_b = sval(b_neg_reg[2], b_mag_reg[2]);
                end
                3'd4:
                begin
                    op_a = sval(a_neg_reg[0], a_mag_reg[0]);
                    op_b = sval(b_neg_reg[1], b_mag_reg[1]);
                end
                3'd5:
                begin
                    op_a = sval(a_neg_reg[1], a_mag_reg[1]);
                    op_b = sval(b_neg_reg[0], b_mag_reg[0]);
                end
                default:
                begin
                    op_a = '0;
                    op_b = '0;
                end
            endcase
        end
        else if (state_reg == S_SQ && mcnt_reg < 3'd3)
        begin
            op_a = $signed({4'd0, m_reg[mcnt_reg[1:0]][29:0]});
            op_b = op_a;
        end
        else if (state_reg == S_OMUL)
        begin
            op_a = $signed({2'd0, q_reg});
            op_b = $signed({2'd0, half_width});
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (render) state_next = S_LOAD;
            S_LOAD:   state_next = last_pt ? S_UPPER : S_SHRINK;
            S_SHRINK: if (!a_big && !b_big) state_next = S_CROSS;
            S_CROSS:  if (mcnt_reg == 3'd6) state_next = S_ZTEST;
            S_ZTEST:
                if (c_reg[0] == '0 && c_reg[1] == '0 && c_reg[2] == '0)
                    state_next = S_UPPER;
                else
                    state_next = S_NORM;
            S_NORM:   if (!m_small && !m_large) state_next = S_SQ;
            S_SQ:     if (mcnt_reg == 3'd3) state_next = S_SQRT;
            S_SQRT:   if (icnt_reg == 5'd31) state_next = S_DINIT;
            S_DINIT:  state_next = S_DIV;
            S_DIV:    if (icnt_reg == 5'd31) state_next = S_OMUL;
            S_OMUL:
                if (mcnt_reg == 3'd1)
                    state_next = (kcnt_reg == 2'd2) ? S_UPPER : S_DINIT;
            S_UPPER:  state_next = S_LOWER;
            S_LOWER:  state_next = last_pt ? S_IDLE : S_LOAD;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pcnt_reg  <= '0;
            mcnt_reg  <= '0;
            icnt_reg  <= '0;
            kcnt_reg  <= '0;
            rot_reg   <= 1'b0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rv_reg    <= (state_reg == S_UPPER) || (state_reg == S_LOWER);
            rot_reg   <= (state_reg == S_LOWER);
            if (state_reg == S_IDLE)
                pcnt_reg <= '0;
            else if (state_reg == S_LOWER)
                pcnt_reg <= pcnt_reg + 1'b1;
            if (state_reg != state_next)
                mcnt_reg <= '0;
            else if (state_reg == S_CROSS || state_reg == S_SQ || state_reg == S_OMUL)
                mcnt_reg <= mcnt_reg + 3'd1;
            if (state_reg == S_SQRT || state_reg == S_DIV)
                icnt_reg <= icnt_reg + 5'd1;
            else
                icnt_reg <= '0;
            if (state_reg == S_SQ)
                kcnt_reg <= '0;
            else if (state_reg == S_OMUL && mcnt_reg == 3'd1)
                kcnt_reg <= kcnt_reg + 2'd1;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
                cam_reg <= cam_pt;
            S_LOAD:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    logic signed [32:0] da, db;
                    da = 33'($signed(p_v[k])) - 33'($signed(c_v[k]));
                    db = 33'($signed(p_v[k])) - 33'($signed(n_v[k]));
                    a_neg_reg[k] <= da[32];
                    a_mag_reg[k] <= da[32] ? 33'(-da) : 33'(da);
                    b_neg_reg[k] <= db[32];
                    b_mag_reg[k] <= db[32] ? 33'(-db) : 33'(db);
                    o_reg[k] <= '0;
                end
            end
            S_SHRINK:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if (a_big) a_mag_reg[k] <= a_mag_reg[k] >> 1;
                    if (b_big) b_mag_reg[k] <= b_mag_reg[k] >> 1;
                end
            end
            S_CROSS:
            begin
                // accumulate the product issued in the previous cycle
                if (mcnt_reg != 3'd0 && mcnt_reg < 3'd7)
                begin
                    if (!j[0])
                        c_reg[j[2:1]] <= prod[47:0];
                    else
                        c_reg[j[2:1]] <= c_reg[j[2:1]] - prod[47:0];
                end
            end
            S_ZTEST:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    c_neg_reg[k] <= c_reg[k][47];
                    m_reg[k]     <= c_reg[k][47] ? 47'(-c_reg[k]) : 47'(c_reg[k]);
                end
            end
            S_NORM:
            begin
                len2_reg <= '0;
                for (int k = 0; k < 3; k++)
                begin
                    if (m_small)
                        m_reg[k] <= m_reg[k] << 1;
                    else if (m_large)
                        m_reg[k] <= m_reg[k] >> 1;
                end
            end
            S_SQ:
            begin
                if (mcnt_reg != 3'd0)
                    len2_reg <= len2_reg + prod[61:0];
                n_reg   <= 64'(len2_reg + (mcnt_reg != 3'd0 ? prod[61:0] : 62'd0));
                r_reg   <= '0;
                bit_reg <= 64'd1 << 62;
            end
            S_SQRT:
            begin
                if (n_reg >= sq_try)
                begin
                    n_reg <= n_reg - sq_try;
                    r_reg <= (r_reg >> 1) + bit_reg;
                end
                else
                    r_reg <= r_reg >> 1;
                bit_reg <= bit_reg >> 2;
                q_reg   <= 32'(((n_reg >= sq_try) ? ((r_reg >> 1) + bit_reg) : (r_reg >> 1)));
            end
            S_DINIT:
            begin
                // q holds the length here; hand it to the divider
                low_reg <= num[31:0];
                rem_reg <= 33'(num[60:32]);
                r_reg   <= 64'(q_reg);
            end
            S_DIV:
            begin
                if (rem_sh >= {1'b0, r_reg[31:0]})
                begin
                    rem_reg <= rem_sh - {1'b0, r_reg[31:0]};
                    q_reg   <= {q_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    q_reg   <= {q_reg[30:0], 1'b0};
                end
                low_reg <= low_reg << 1;
            end
            S_OMUL:
            begin
                if (mcnt_reg == 3'd1)
                begin
                    o_reg[kcnt_reg] <= c_neg_reg[kcnt_reg] ? -o_mag : o_mag;
                    q_reg <= r_reg[31:0];
                end
            end
            S_UPPER:
            begin
                res_reg.vert_x     <= p_v[0] + o_reg[0];
                res_reg.vert_y     <= p_v[1] + o_reg[1];
                res_reg.vert_z     <= p_v[2] + o_reg[2];
                res_reg.lower_edge <= 1'b0;
                res_reg.last       <= 1'b0;
            end
            S_LOWER:
            begin
                res_reg.vert_x     <= p_v[0] - o_reg[0];
                res_reg.vert_y     <= p_v[1] - o_reg[1];
                res_reg.vert_z     <= p_v[2] - o_reg[2];
                res_reg.lower_edge <= 1'b1;
                res_reg.last       <= last_pt;
            end
            default:
            begin
                res_reg <= res_reg;
            end
        endcase
    end

    // Advance the history at the end of each lower vertex so the next load
    // sees the next point; rot_reg keeps busy high while the final vertex shows.
    assign hctl.push     = 1'b0;
    assign hctl.rotate   = (state_reg == S_LOWER);
    assign busy          = (state_reg != S_IDLE) || rot_reg;
    assign result_valid  = rv_reg;
    assign result        = res_reg;

endmodule

@@ sv/rtv_checker.sv @@
// Port-level checks of the ribbon generator and their bind.
module rtv_checker
    import rtv_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input item_t   item,
    input logic    result_valid,
    input result_t result
);

    a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("vertex outside a render");

    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.lower_edge |=> result_valid && result.lower_edge)
        else $error("upper vertex not followed by lower");

    a_last_lower: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last |-> result.lower_edge)
        else $error("last on upper vertex");

    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last |=> !busy && !result_valid)
        else $error("busy after last vertex");

    a_push_fast: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && item.command == CMD_PUSH |=> !busy && !result_valid)
        else $error("push made block busy");

endmodule

bind ribbon_trail_vertex_generator rtv_checker u_rtv_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result)
);
